@@ design/b64e_pkg.sv @@
// Shared types, constants and the character mapping of the base64 stream encoder.
package b64e_pkg;

  // Group position codes for the front classifier
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // Symbol: top bit marks a pad, low six bits hold a sextet
  localparam int unsigned SYM_W = 7;
  localparam logic [SYM_W-1:0] SYM_PAD = 7'h40;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Queue between classifier and emitter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SYM_W-1:0] sym_t;

  // One classified input word: up to four symbols to emit
  typedef struct packed {
    sym_t [3:0] syms;      // syms[0] goes out first
    logic [1:0] last_idx;  // index of the final symbol of this word
    logic       fin;       // word closes the message
  } job_t;

  // Queue status seen by the front side
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  // Queue status seen by the back side
  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

  // Map a symbol onto the standard alphabet, or the pad character
  function automatic logic [7:0] sym_to_char(input sym_t s);
    logic [7:0] v;
    logic [7:0] c;
    v = {2'b00, s[5:0]};
    if (s[6]) begin
      c = CHAR_PAD;
    end else if (v < 8'd26) begin
      c = v + 8'd65;
    end else if (v < 8'd52) begin
      c = v + 8'd71;
    end else if (v < 8'd62) begin
      c = v - 8'd4;
    end else if (v == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

@@ design/base64_stream_encoder.sv @@
// Each byte's characters pass through the queue and then the output register.
// Throughput: one character per cycle while the output is not stalled; a byte makes
// one or two characters mid-stream (up to four on the last byte), so the byte rate is
// set by the single-character output port. A two-word queue decouples input.
// Reset: asynchronous, active low; clears group position, queue and output valid.
// Top level of the streaming base64 encoder.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       end_of_run_o,
  output logic       end_of_message_o
);

  b64e_pkg::q_wr_t q_wr;
  b64e_pkg::q_rd_t q_rd;
  b64e_pkg::job_t  job, head;
  logic            q_full, pop;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_final_i  (is_final_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .job_o       (job)
  );

  b64e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .rd_o   (q_rd),
    .head_o (head)
  );

  b64e_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rd_i             (q_rd),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .end_of_run_o     (end_of_run_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

@@ design/b64e_front.sv @@
// Front classifier: accepts bytes, tracks the group position and builds symbol words.
module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             is_final_i,
  input  logic             q_full_i,
  output b64e_pkg::q_wr_t  q_wr_o,
  output b64e_pkg::job_t   job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign q_wr_o.push = accept;
  assign q_wr_o.full = q_full_i;

  // Split the byte against the carried bits
  always_comb begin
    job_o.syms     = '{default: b64e_pkg::SYM_PAD};
    job_o.last_idx = 2'd0;
    job_o.fin      = is_final_i;
    phase_d        = phase_q;
    left_d         = left_q;
    unique case (phase_q)
      b64e_pkg::PHASE_SECOND: begin
        job_o.syms[0] = {1'b0, left_q[1:0], data_byte_i[7:4]};
        left_d        = data_byte_i[3:0];
        phase_d       = b64e_pkg::PHASE_THIRD;
        if (is_final_i) begin
          job_o.syms[1]  = {1'b0, data_byte_i[3:0], 2'b00};
          job_o.last_idx = 2'd2;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        job_o.syms[0]  = {1'b0, left_q, data_byte_i[7:6]};
        job_o.syms[1]  = {1'b0, data_byte_i[5:0]};
        job_o.last_idx = 2'd1;
        left_d         = 4'd0;
        phase_d        = b64e_pkg::PHASE_FIRST;
      end
      default: begin
        job_o.syms[0] = {1'b0, data_byte_i[7:2]};
        left_d        = {2'b00, data_byte_i[1:0]};
        phase_d       = b64e_pkg::PHASE_SECOND;
        if (is_final_i) begin
          job_o.syms[1]  = {1'b0, data_byte_i[1:0], 4'b0000};
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    // Restart the group after the last byte
    if (is_final_i) begin
      phase_d = b64e_pkg::PHASE_FIRST;
      left_d  = 4'd0;
    end
  end

  // Advance group state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PHASE_FIRST;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ design/b64e_queue.sv @@
// Short register queue of symbol words between the classifier and the emitter.
module b64e_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64e_pkg::q_wr_t wr_i,
  input  b64e_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output b64e_pkg::q_rd_t rd_o,
  output b64e_pkg::job_t  head_o
);

  b64e_pkg::job_t                 entry_q [b64e_pkg::QUEUE_DEPTH];
  logic [b64e_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o    = (cnt_q == b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH));
  assign rd_o.empty = (cnt_q == '0);
  assign rd_o.pop   = do_pop;
  assign head_o    = entry_q[rd_ptr_q];

  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !rd_o.empty;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Hold stored words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ design/b64e_back.sv @@
// Back emitter: walks the head word symbol by symbol into the output register.
module b64e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64e_pkg::q_rd_t rd_i,
  input  b64e_pkg::job_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            end_of_run_o,
  output logic            end_of_message_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       eor_q, eom_q;
  logic       load, is_last;

  assign load    = (!valid_q || !out_stall_i) && !rd_i.empty;
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  assign out_valid_o      = valid_q;
  assign out_char_o       = char_q;
  assign end_of_run_o     = eor_q;
  assign end_of_message_o = eom_q;

  // Step through symbols and drop the valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= b64e_pkg::sym_to_char(head_i.syms[idx_q]);
      eor_q  <= is_last;
      eom_q  <= is_last && head_i.fin;
    end
  end

endmodule

@@ design/b64e_checker.sv @@
// Port-level checks of the base64 stream encoder and their binding.
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       end_of_run_o,
  input logic       end_of_message_o
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o))
    else $error("stalled output word changed");

  // End of message only closes a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_message_o |-> end_of_run_o)
    else $error("end of message without end of run");

  // A pad that closes a run closes the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_char_o == b64e_pkg::CHAR_PAD && end_of_run_o |-> end_of_message_o)
    else $error("pad run not at end of message");

  // A taken pad that does not close the run is followed at once by another pad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_char_o == b64e_pkg::CHAR_PAD && !end_of_run_o
    |=> out_valid_o && out_char_o == b64e_pkg::CHAR_PAD)
    else $error("second pad missing");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_char_o       (out_char_o),
  .end_of_run_o     (end_of_run_o),
  .end_of_message_o (end_of_message_o)
);

@@ sim/b64e_stream_monitor.sv @@
// Watches both channels of the base64 encoder, predicts each character and compares it.
module b64e_stream_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic       end_of_run_i,
  input  logic       end_of_message_i,
  output int         chars_pending_o,
  output int         mismatches_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Standard alphabet, entry 0 is 'A'
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } b64_char_t;

  b64_char_t  expected_chars[$];
  logic [1:0] group_pos;
  logic [3:0] carry_bits;

  initial begin
    chars_pending_o = 0;
    mismatches_o    = 0;
  end

  // Encode one byte: queue the characters it completes and advance the group position
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] chars [4];
    int         n;
    b64_char_t  c;
    n = 0;
    case (group_pos)
      b64e_pkg::PHASE_SECOND: begin
        chars[0]   = B64_ALPHABET[{carry_bits[1:0], b[7:4]}];
        n          = 1;
        carry_bits = b[3:0];
        group_pos  = b64e_pkg::PHASE_THIRD;
        if (fin) begin
          chars[1] = B64_ALPHABET[{b[3:0], 2'b00}];
          chars[2] = b64e_pkg::CHAR_PAD;
          n        = 3;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        chars[0]   = B64_ALPHABET[{carry_bits, b[7:6]}];
        chars[1]   = B64_ALPHABET[b[5:0]];
        n          = 2;
        carry_bits = '0;
        group_pos  = b64e_pkg::PHASE_FIRST;
      end
      default: begin
        // an unused position behaves as the start of a group
        chars[0]   = B64_ALPHABET[b[7:2]];
        n          = 1;
        carry_bits = {2'b00, b[1:0]};
        group_pos  = b64e_pkg::PHASE_SECOND;
        if (fin) begin
          chars[1] = B64_ALPHABET[{b[1:0], 4'b0000}];
          chars[2] = b64e_pkg::CHAR_PAD;
          chars[3] = b64e_pkg::CHAR_PAD;
          n        = 4;
        end
      end
    endcase
    if (fin) begin
      group_pos  = b64e_pkg::PHASE_FIRST;
      carry_bits = '0;
    end
    for (int k = 0; k < n; k++) begin
      c.ch      = chars[k];
      c.run_end = (k == n - 1);
      c.msg_end = (k == n - 1) && fin;
      expected_chars.push_back(c);
    end
  endfunction

  // Compare accepted characters first, then predict from the accepted byte word
  always @(posedge clk_i or negedge rst_ni) begin
    b64_char_t want;
    if (!rst_ni) begin
      group_pos  = b64e_pkg::PHASE_FIRST;
      carry_bits = '0;
      expected_chars.delete();
      chars_pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output word: out_char %h end_of_run %b end_of_message %b",
                 out_char_i, end_of_run_i, end_of_message_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char_i);
            mismatches_o = mismatches_o + 1;
          end
          if (end_of_run_i !== want.run_end) begin
            $error("end_of_run: expected %b, got %b", want.run_end, end_of_run_i);
            mismatches_o = mismatches_o + 1;
          end
          if (end_of_message_i !== want.msg_end) begin
            $error("end_of_message: expected %b, got %b", want.msg_end, end_of_message_i);
            mismatches_o = mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_byte(data_byte_i, is_final_i);
      end
      chars_pending_o <= expected_chars.size();
    end
  end

endmodule

@@ sim/base64_stream_encoder_test.sv @@
// Stimulus, clock, reset and verdict for the base64 stream encoder.
module base64_stream_encoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [7:0] data_byte_i      = 8'h00;
  logic       is_final_i       = 1'b0;
  logic       out_stall_i      = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       end_of_run_o;
  logic       end_of_message_o;

  int chars_pending;
  int mismatches;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit idle_on     = 1'b1;

  base64_stream_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .is_final_i      (is_final_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .end_of_run_o    (end_of_run_o),
    .end_of_message_o(end_of_message_o)
  );

  b64e_stream_monitor monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .is_final_i      (is_final_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_i      (out_char_o),
    .end_of_run_i    (end_of_run_o),
    .end_of_message_i(end_of_message_o),
    .chars_pending_o (chars_pending),
    .mismatches_o    (mismatches)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap length: mostly none or short, a few long; none while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  // Offer one byte word and hold it until accepted; called at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_final_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Send a whole message, marking its last byte
  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Random message bytes, biased toward the all-zero and all-one extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Stall the output side at random
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0] msg[$];
    int         len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte, two-byte and full-group endings, alphabet edges
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'h00, 8'hFF});
    send_message('{8'hFF, 8'h00});
    send_message('{8'h4D, 8'h61, 8'h6E});
    send_message('{8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});

    // Random messages: mostly short, now and then a long one
    while (bytes_sent < 205) begin
      idle_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      msg.delete();
      repeat (len) msg.push_back(pick_byte());
      send_message(msg);
    end
    idle_on = 1'b1;

    // Drain: wait for every expected character, then a short tail
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && chars_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
